>>> rtl/overwriting_log_ring_buffer_unit_macros.svh
// assertion macros for the overwriting log ring buffer unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef OVERWRITING_LOG_RING_BUFFER_UNIT_MACROS_SVH
`define OVERWRITING_LOG_RING_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define OLRB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("olrb assertion failed");

// next-cycle implication, disabled in reset
`define OLRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("olrb assertion failed");

`endif

>>> rtl/olrb_pkg.sv
// shared types and constants of the overwriting log ring buffer unit
// no dependencies
`default_nettype none

package olrb_pkg;

    localparam int DEPTH      = 64;
    localparam int ENTRY_BITS = 64;

    localparam int OPC_W  = 2;
    localparam int DATA_W = 64;
    localparam int LIM_W  = 7;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > LIM_W) ? CW : LIM_W;
    localparam int STW   = AW + 1;

    localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] entry_data;
        logic [LIM_W-1:0]  read_limit;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] out_entry;
        logic              is_empty;
        logic              is_last;
    } t_out_item;

    typedef struct packed {
        logic wr;
        logic rd_start;
        logic clr;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic left_le1;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/olrb_ctrl.sv
// controller of the log ring buffer: idle / drain state machine
// depends on olrb_pkg
`default_nettype none

module olrb_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [olrb_pkg::OPC_W-1:0] i_opcode,
    input  wire olrb_pkg::t_stat           i_stat,
    output logic                           o_in_stall,
    output olrb_pkg::t_cmd                 o_cmd
);
    import olrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign w_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd.wr       = w_acc && (i_opcode == OP_WRITE);
        o_cmd.rd_start = w_acc && (i_opcode == OP_READ);
        o_cmd.clr      = w_acc && (i_opcode == OP_CLEAR);
        o_cmd.load     = (r_state == ST_DRAIN) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.rd_start) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                // leave once the final item of the read is loaded
                if (o_cmd.load && i_stat.left_le1) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/olrb_dp.sv
// datapath of the log ring buffer: entry memory, pointers, fill count, output register
// depends on olrb_pkg
`default_nettype none

module olrb_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire olrb_pkg::t_in_item i_in_data,
    input  wire olrb_pkg::t_cmd     i_cmd,
    input  wire logic               i_out_stall,
    output olrb_pkg::t_stat         o_stat,
    output logic                    o_out_valid,
    output olrb_pkg::t_out_item     o_out_data
);
    import olrb_pkg::*;

    logic [ENTRY_BITS-1:0] r_mem [DEPTH];
    logic [ENTRY_BITS-1:0] r_rd_data;

    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_left, n_left;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic          r_out_valid, n_out_valid;
    logic          r_out_empty, r_out_last;

    logic [CMP_W-1:0] w_fill_x, w_lim_x, w_cnt_x;
    logic [CW-1:0]    w_cnt;
    logic [STW-1:0]   w_start_x;
    logic [AW-1:0]    w_start;
    logic             w_has_entry;

    // entries to return: fill count limited by the request, and the ring index of the oldest one
    always_comb begin
        w_fill_x = CMP_W'(r_fill);
        w_lim_x  = CMP_W'(i_in_data.read_limit);
        w_cnt_x  = (w_fill_x < w_lim_x) ? w_fill_x : w_lim_x;
        w_cnt    = CW'(w_cnt_x);
        w_start_x = STW'(r_wr_pos) + STW'(DEPTH) - STW'(w_cnt);
        if (w_start_x >= STW'(DEPTH)) begin
            w_start_x = w_start_x - STW'(DEPTH);
        end
        w_start = w_start_x[AW-1:0];
    end

    assign w_has_entry = (r_left != '0);

    always_comb begin
        n_wr_pos = r_wr_pos;
        n_fill   = r_fill;
        n_left   = r_left;
        n_rd_idx = r_rd_idx;
        if (i_cmd.wr) begin
            n_wr_pos = (r_wr_pos == AW'(DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
            n_fill   = (r_fill == CW'(DEPTH)) ? r_fill : r_fill + 1'b1;
        end
        if (i_cmd.rd_start) begin
            n_fill   = '0;
            n_left   = w_cnt;
            n_rd_idx = w_start;
        end
        if (i_cmd.clr) begin
            n_wr_pos = '0;
            n_fill   = '0;
        end
        if (i_cmd.load && w_has_entry) begin
            n_left   = r_left - 1'b1;
            n_rd_idx = (r_rd_idx == AW'(DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pos    <= n_wr_pos;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        if (i_cmd.load) begin
            // no entry left at a load means an empty read
            r_out_empty <= !w_has_entry;
            r_out_last  <= (r_left <= CW'(1));
        end
    end

    // entry memory, registered read straight into the output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wr_pos] <= i_in_data.entry_data[ENTRY_BITS-1:0];
        end
        if (i_cmd.load && w_has_entry) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.left_le1 = (r_left <= CW'(1));

    assign o_out_valid          = r_out_valid;
    assign o_out_data.out_entry = r_out_empty ? '0 : DATA_W'(r_rd_data);
    assign o_out_data.is_empty  = r_out_empty;
    assign o_out_data.is_last   = r_out_last;

endmodule

`default_nettype wire

>>> rtl/overwriting_log_ring_buffer_unit.sv
// writes and clears: one item per cycle while no read is draining, no result
// read of N entries: the read moves the controller to its drain state, which loads the
// results into the output register one per cycle as the output takes them (one empty
// result if N is 0); input stalls until the last result is loaded (fill count caps N)
// reset clears write position, fill count, drain state and output valid; memory keeps data
`default_nettype none

`include "overwriting_log_ring_buffer_unit_macros.svh"

module overwriting_log_ring_buffer_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire olrb_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output olrb_pkg::t_out_item     o_out_data
);
    import olrb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    olrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    olrb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `OLRB_ASSERT_NOW(a_load_when_free, w_cmd.load, w_stat.out_free)
    `OLRB_ASSERT_NEXT(a_read_stalls_input, w_cmd.rd_start, o_in_stall)
    `OLRB_ASSERT_NOW(a_empty_is_last, o_out_valid && o_out_data.is_empty, o_out_data.is_last)
    `OLRB_ASSERT_NOW(a_empty_zero, o_out_valid && o_out_data.is_empty, o_out_data.out_entry == '0)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for overwriting_log_ring_buffer_unit: directed rows, then random
// write runs (closed by a read, a clear or nothing) and stray items; needs olrb_pkg and the unit

module tb_top;

    import olrb_pkg::*;

    localparam logic [OPC_W-1:0]  OP_UNUSED      = 2'd3;
    localparam logic [DATA_W-1:0] ENTRY_MASK     = {DATA_W{1'b1}} >> (DATA_W - ENTRY_BITS);
    localparam int                RAND_ITEMS     = 250;
    localparam int                WATCHDOG_LIMIT = 3000;
    localparam int                SETTLE_CYCLES  = 20;

    localparam t_out_item EMPTY_RESULT = '{out_entry: '0, is_empty: 1'b1, is_last: 1'b1};
    localparam t_out_item NO_RESULT    = '0;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SCATTER,
        STALL_ALTERNATE,
        STALL_LONG
    } t_stall_mode;

    typedef struct {
        t_in_item  item;
        bit        pinned;
        t_out_item res;
    } t_dir_row;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // typed-in expectation that travels with the item on the input channel
    bit        in_pinned  = 1'b0;
    t_out_item in_pin_res = '0;

    // predictor state
    logic [ENTRY_BITS-1:0] ring_mem [DEPTH];
    logic [AW-1:0]         ring_wr_pos = '0;
    logic [CW-1:0]         ring_fill   = '0;
    t_out_item             pending_entries[$];

    int fails        = 0;
    int items_sent   = 0;
    int reads_seen   = 0;
    int results_seen = 0;
    int deepest_read = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    bit steady       = 1'b0;

    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;

    overwriting_log_ring_buffer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // works out the entries a read should return and keeps the ring state in step
    task automatic log_ring_predict(input t_in_item it, input bit pinned,
                                    input t_out_item pin_res);
        t_out_item produced[$];
        int count;
        int first;
        case (it.opcode)
            OP_WRITE: begin
                ring_mem[ring_wr_pos] = ENTRY_BITS'(it.entry_data & ENTRY_MASK);
                ring_wr_pos = AW'((int'(ring_wr_pos) + 1) % DEPTH);
                if (int'(ring_fill) < DEPTH) ring_fill = ring_fill + 1'b1;
            end
            OP_READ: begin
                count = int'(ring_fill);
                ring_fill = '0;
                if (count > int'(it.read_limit)) count = int'(it.read_limit);
                if (count > DEPTH) count = DEPTH;
                reads_seen++;
                if (count > deepest_read) deepest_read = count;
                if (count == 0) begin
                    produced.push_back(EMPTY_RESULT);
                end else begin
                    first = (int'(ring_wr_pos) + DEPTH - count) % DEPTH;
                    for (int i = 0; i < count; i++) begin
                        produced.push_back('{out_entry: DATA_W'(ring_mem[(first + i) % DEPTH]),
                                             is_empty: 1'b0,
                                             is_last: (i == count - 1)});
                    end
                end
            end
            OP_CLEAR: begin
                ring_wr_pos = '0;
                ring_fill   = '0;
            end
            default: ;
        endcase
        if (pinned) begin
            pending_entries.push_back(pin_res);
        end else begin
            foreach (produced[i]) pending_entries.push_back(produced[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && !in_stall) log_ring_predict(in_data, in_pinned, in_pin_res);
            if (out_valid && !out_stall) begin
                results_seen++;
                if (pending_entries.size() == 0) begin
                    $error("unexpected item: out_entry %h is_empty %b is_last %b",
                           out_data.out_entry, out_data.is_empty, out_data.is_last);
                    fails++;
                end else begin
                    want = pending_entries.pop_front();
                    if (out_data.out_entry !== want.out_entry) begin
                        $error("out_entry: expected %h, actual %h",
                               want.out_entry, out_data.out_entry);
                        fails++;
                    end
                    if (out_data.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %b, actual %b",
                               want.is_empty, out_data.is_empty);
                        fails++;
                    end
                    if (out_data.is_last !== want.is_last) begin
                        $error("is_last: expected %b, actual %b",
                               want.is_last, out_data.is_last);
                        fails++;
                    end
                end
            end
        end
    end

    // receiver stall pattern, switching style at random intervals
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(40, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE:      out_stall <= 1'b0;
            STALL_SCATTER:   out_stall <= ($urandom_range(0, 3) == 0);
            STALL_ALTERNATE: out_stall <= ~out_stall;
            default:         out_stall <= out_stall ? ($urandom_range(0, 7) != 0)
                                                    : ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item, hold it until taken, then maybe open a gap
    task automatic send_item(input t_in_item it, input bit pinned, input t_out_item pin_res);
        int gap;
        in_valid   <= 1'b1;
        in_data    <= it;
        in_pinned  <= pinned;
        in_pin_res <= pin_res;
        do @(posedge i_clk); while (in_stall);
        if (it.opcode != OP_UNUSED) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if (!steady) begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit(input int run);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return LIM_W'($urandom_range(0, 3));
        if (roll < 50) return LIM_W'($urandom_range(0, 127));
        if (roll < 70) return LIM_W'(run > 127 ? 127 : run);
        if (roll < 85) return LIM_W'(run + $urandom_range(1, 8) > 127 ? 127
                                     : run + $urandom_range(1, 8));
        if (roll < 92) return LIM_W'(DEPTH);
        return '1;
    endfunction

    function automatic t_dir_row mk_row(input logic [OPC_W-1:0] op,
                                        input logic [DATA_W-1:0] d,
                                        input logic [LIM_W-1:0] lim,
                                        input bit pinned, input t_out_item res);
        t_dir_row r;
        r.item.opcode     = op;
        r.item.entry_data = d;
        r.item.read_limit = lim;
        r.pinned          = pinned;
        r.res             = res;
        return r;
    endfunction

    initial begin
        t_dir_row dir_rows[$];
        t_in_item item;
        int       rand_target;
        int       seq_idx;
        int       run;
        int       roll;

        // read right after reset, unused opcode, then single-entry extremes
        dir_rows.push_back(mk_row(OP_READ,   '0, 7'd64, 1'b1, EMPTY_RESULT));
        dir_rows.push_back(mk_row(OP_UNUSED, '1, '1,    1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '1, 7'd64, 1'b1, EMPTY_RESULT));
        dir_rows.push_back(mk_row(OP_WRITE,  '1, '0,    1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, 7'd1,  1'b1,
                                  '{out_entry: ENTRY_MASK, is_empty: 1'b0, is_last: 1'b1}));
        dir_rows.push_back(mk_row(OP_WRITE,  '0, '1,    1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, '1,    1'b1,
                                  '{out_entry: '0, is_empty: 1'b0, is_last: 1'b1}));
        // zero limit drops what was stored
        dir_rows.push_back(mk_row(OP_WRITE,  64'ha5a5_a5a5_a5a5_a5a5, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_WRITE,  64'h5a5a_5a5a_5a5a_5a5a, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, 7'd0,  1'b1, EMPTY_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, 7'd64, 1'b1, EMPTY_RESULT));
        // limit below the count keeps only the newest
        dir_rows.push_back(mk_row(OP_WRITE,  64'h0123_4567_89ab_cdef, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_WRITE,  64'hfedc_ba98_7654_3210, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_WRITE,  64'h5555_5555_5555_5555, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, 7'd2,  1'b0, NO_RESULT));
        // clear with entries pending
        dir_rows.push_back(mk_row(OP_WRITE,  64'haaaa_aaaa_aaaa_aaaa, '1, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_WRITE,  64'h1, '1, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_CLEAR,  '1, '1,    1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, '1,    1'b1, EMPTY_RESULT));
        // limit above depth returns only what is stored
        dir_rows.push_back(mk_row(OP_WRITE,  64'h8000_0000_0000_0001, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_WRITE,  64'h7fff_ffff_ffff_fffe, '0, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_READ,   '0, '1,    1'b0, NO_RESULT));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        steady = 1'b1;
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].res);
        drain_pause();

        // write runs of random length, each closed by a read, a clear, or left open
        rand_target = items_sent + RAND_ITEMS;
        seq_idx     = 0;
        while (items_sent < rand_target) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 8) begin
                item.opcode     = OPC_W'($urandom_range(0, 3));
                item.entry_data = pick_entry();
                item.read_limit = LIM_W'($urandom_range(0, 127));
                send_item(item, 1'b0, NO_RESULT);
            end else begin
                roll = $urandom_range(0, 99);
                if (seq_idx == 2)   run = $urandom_range(DEPTH + 2, DEPTH + 26);
                else if (roll < 4)  run = 0;
                else if (roll < 84) run = $urandom_range(1, 8);
                else if (roll < 96) run = $urandom_range(9, 40);
                else                run = $urandom_range(60, 100);
                repeat (run) begin
                    item.opcode     = OP_WRITE;
                    item.entry_data = pick_entry();
                    item.read_limit = LIM_W'($urandom_range(0, 127));
                    send_item(item, 1'b0, NO_RESULT);
                end
                roll = $urandom_range(0, 99);
                if (roll < 92) begin
                    item.opcode     = (roll < 80) ? OP_READ : OP_CLEAR;
                    item.entry_data = pick_entry();
                    item.read_limit = pick_limit(run);
                    send_item(item, 1'b0, NO_RESULT);
                end
            end
            seq_idx++;
            if (seq_idx == 3 || $urandom_range(0, 11) == 0) drain_pause();
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d items and %0d reads, %0d results checked", items_sent,
                 reads_seen, results_seen);
        $display("deepest read returned %0d entries, %0d field mismatches", deepest_read,
                 fails);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
